>>> hw/rtl/vaw_pkg.sv
// Shared types and constants for the vibration activity window core.
// No dependencies; used by vaw_dp, vaw_ctrl and the top level.
package vaw_pkg;

  localparam int unsigned MsW = 17;
  localparam logic [MsW-1:0] MS_PER_BUCKET = 17'd1000;

  typedef enum logic [2:0] {
    CMD_SAMPLE = 3'd0,
    CMD_TICK   = 3'd1,
    CMD_WAKE   = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_TAKE   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    REG_VIB_THR     = 2'd0,
    REG_RUN_THR     = 2'd1,
    REG_REPORT_IVL  = 2'd2,
    REG_QUIET_TMO   = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EXEC,
    ST_CHECK,
    ST_COMMIT,
    ST_DRAIN,
    ST_REPORT,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic sweep;
    logic commit;
    logic drain;
    logic report;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic is_clear;
    logic need_commit;
    logic sweep_last;
    logic out_free;
  } dp_sts_t;

endpackage

>>> hw/rtl/vaw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vaw_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/vaw_dp.sv
// Datapath: config registers, timers, bucket ring RAM, counters and result register.
// Depends on vaw_pkg and vaw_ram; driven by vaw_ctrl through dp_cmd_t.
module vaw_dp #(
  parameter int unsigned WINDOW_SECONDS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  vaw_pkg::dp_cmd_t cmd_i,
  output vaw_pkg::dp_sts_t sts_o,
  input  logic [2:0]       command_i,
  input  logic [15:0]      magnitude_i,
  input  logic [15:0]      tick_ms_i,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_addr_i,
  input  logic [31:0]      cfg_wdata_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [15:0]      out_data_o
);

  localparam int unsigned AW = $clog2(WINDOW_SECONDS);
  localparam int unsigned CW = $clog2(WINDOW_SECONDS + 1);
  localparam int unsigned MsW = vaw_pkg::MsW;

  // config
  logic [15:0] vib_thr_q;
  logic [6:0]  run_thr_q;
  logic [31:0] report_ivl_q;
  logic [31:0] quiet_tmo_q;

  // item
  logic [2:0]  cmd_q;
  logic [15:0] mag_q;
  logic [15:0] ems_q;

  // state
  logic           active_q, active_d;
  logic [AW-1:0]  pos_q, pos_d, pos_inc;
  logic [CW-1:0]  count_q, count_d;
  logic           sa_q, sa_d;
  logic [MsW-1:0] ms_sec_q, ms_sec_d;
  logic [31:0]    quiet_q, quiet_d;
  logic [31:0]    rpt_q, rpt_d;
  logic           flag_q, flag_d;
  logic [AW-1:0]  swp_q, swp_d;
  logic           oval_q, oval_d;
  logic [15:0]    odata_q;

  logic [32:0]    quiet_sum, rpt_sum;
  logic [CW+6:0]  cnt_ext;
  logic           ram_we, ram_wdata, ram_rdata;
  logic [AW-1:0]  ram_waddr;

  assign pos_inc   = (pos_q == AW'(WINDOW_SECONDS - 1)) ? '0 : pos_q + 1'b1;
  assign quiet_sum = {1'b0, quiet_q} + {17'b0, ems_q};
  assign rpt_sum   = {1'b0, rpt_q} + {17'b0, ems_q};
  assign cnt_ext   = {7'b0, count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vib_thr_q    <= 16'd100;
      run_thr_q    <= 7'd10;
      report_ivl_q <= 32'd60000;
      quiet_tmo_q  <= 32'd300000;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        vaw_pkg::REG_VIB_THR:    vib_thr_q    <= cfg_wdata_i[15:0];
        vaw_pkg::REG_RUN_THR:    run_thr_q    <= cfg_wdata_i[6:0];
        vaw_pkg::REG_REPORT_IVL: report_ivl_q <= cfg_wdata_i;
        vaw_pkg::REG_QUIET_TMO:  quiet_tmo_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= command_i;
      mag_q <= magnitude_i;
      ems_q <= tick_ms_i;
    end
    if (cmd_i.emit) begin
      odata_q <= {5'b0, flag_q,
                  active_q && (quiet_q > quiet_tmo_q),
                  cnt_ext >= {{CW{1'b0}}, run_thr_q},
                  cnt_ext[6:0], active_q};
    end
  end

  always_comb begin
    active_d = active_q;
    pos_d    = pos_q;
    count_d  = count_q;
    sa_d     = sa_q;
    ms_sec_d = ms_sec_q;
    quiet_d  = quiet_q;
    rpt_d    = rpt_q;
    flag_d   = flag_q;
    swp_d    = swp_q;
    oval_d   = oval_q && !out_ready_i;

    if (cmd_i.exec) begin
      if (cmd_q == vaw_pkg::CMD_SAMPLE) begin
        if (mag_q >= vib_thr_q) begin
          sa_d    = 1'b1;
          quiet_d = '0;
        end
      end else if (cmd_q == vaw_pkg::CMD_TICK) begin
        ms_sec_d = ms_sec_q + {1'b0, ems_q};
        quiet_d  = quiet_sum[32] ? '1 : quiet_sum[31:0];
        rpt_d    = rpt_sum[32] ? '1 : rpt_sum[31:0];
      end else if (cmd_q == vaw_pkg::CMD_WAKE) begin
        active_d = 1'b1;
        quiet_d  = '0;
      end else if (cmd_q == vaw_pkg::CMD_CLEAR) begin
        active_d = 1'b0;
        pos_d    = '0;
        count_d  = '0;
        sa_d     = 1'b0;
        ms_sec_d = '0;
        quiet_d  = '0;
        rpt_d    = '0;
        flag_d   = 1'b0;
        swp_d    = '0;
      end
    end

    if (cmd_i.sweep) begin
      swp_d = swp_q + 1'b1;
    end

    // slot at pos is always empty here, so writing the second bit only adds
    if (cmd_i.commit) begin
      count_d  = count_q + CW'(sa_q);
      sa_d     = 1'b0;
      pos_d    = pos_inc;
      ms_sec_d = ms_sec_q - vaw_pkg::MS_PER_BUCKET;
    end

    if (cmd_i.drain) begin
      count_d = count_q - CW'(ram_rdata);
    end

    if (cmd_i.report && active_q && (rpt_q >= report_ivl_q)) begin
      rpt_d  = '0;
      flag_d = 1'b1;
    end

    if (cmd_i.emit) begin
      oval_d = 1'b1;
      if (cmd_q == vaw_pkg::CMD_TAKE) begin
        flag_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pos_q    <= '0;
      count_q  <= '0;
      sa_q     <= 1'b0;
      ms_sec_q <= '0;
      quiet_q  <= '0;
      rpt_q    <= '0;
      flag_q   <= 1'b0;
      swp_q    <= '0;
      oval_q   <= 1'b0;
    end else begin
      active_q <= active_d;
      pos_q    <= pos_d;
      count_q  <= count_d;
      sa_q     <= sa_d;
      ms_sec_q <= ms_sec_d;
      quiet_q  <= quiet_d;
      rpt_q    <= rpt_d;
      flag_q   <= flag_d;
      swp_q    <= swp_d;
      oval_q   <= oval_d;
    end
  end

  always_comb begin
    ram_we    = cmd_i.sweep || cmd_i.commit || cmd_i.drain;
    ram_waddr = cmd_i.sweep ? swp_q : pos_q;
    ram_wdata = cmd_i.commit ? sa_q : 1'b0;
  end

  vaw_ram #(
    .WIDTH (1),
    .DEPTH (WINDOW_SECONDS)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (pos_inc),
    .rdata_o (ram_rdata)
  );

  assign sts_o.is_tick     = (cmd_q == vaw_pkg::CMD_TICK);
  assign sts_o.is_clear    = (cmd_q == vaw_pkg::CMD_CLEAR);
  assign sts_o.need_commit = (ms_sec_q >= vaw_pkg::MS_PER_BUCKET);
  assign sts_o.sweep_last  = (swp_q == AW'(WINDOW_SECONDS - 1));
  assign sts_o.out_free    = !oval_q || out_ready_i;

  assign out_valid_o = oval_q;
  assign out_data_o  = odata_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(WINDOW_SECONDS))
    else $error("bucket count above window size");

  a_ms_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.report |-> ms_sec_q < vaw_pkg::MS_PER_BUCKET)
    else $error("report check before all buckets committed");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> sts_o.out_free)
    else $error("result overwritten before taken");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_i.sweep, cmd_i.commit, cmd_i.drain}) <= 1)
    else $error("ring written from two sources");

endmodule

>>> hw/rtl/vaw_ctrl.sv
// Controller state machine: sequences clear sweep, command execution, bucket commits.
// Depends on vaw_pkg; talks to vaw_dp through dp_cmd_t and dp_sts_t.
module vaw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  vaw_pkg::dp_sts_t sts_i,
  output vaw_pkg::dp_cmd_t cmd_o
);

  vaw_pkg::state_e state_q, state_d;
  logic            pend_q, pend_d;

  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    unique case (state_q)
      vaw_pkg::ST_SWEEP: begin
        if (sts_i.sweep_last) begin
          state_d = pend_q ? vaw_pkg::ST_RESP : vaw_pkg::ST_IDLE;
          pend_d  = 1'b0;
        end
      end
      vaw_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = vaw_pkg::ST_EXEC;
      end
      vaw_pkg::ST_EXEC: begin
        if (sts_i.is_clear) begin
          state_d = vaw_pkg::ST_SWEEP;
          pend_d  = 1'b1;
        end else if (sts_i.is_tick) begin
          state_d = vaw_pkg::ST_CHECK;
        end else begin
          state_d = vaw_pkg::ST_RESP;
        end
      end
      vaw_pkg::ST_CHECK: begin
        state_d = sts_i.need_commit ? vaw_pkg::ST_COMMIT : vaw_pkg::ST_REPORT;
      end
      vaw_pkg::ST_COMMIT: state_d = vaw_pkg::ST_DRAIN;
      vaw_pkg::ST_DRAIN: begin
        state_d = sts_i.need_commit ? vaw_pkg::ST_COMMIT : vaw_pkg::ST_REPORT;
      end
      vaw_pkg::ST_REPORT: state_d = vaw_pkg::ST_RESP;
      vaw_pkg::ST_RESP: begin
        if (sts_i.out_free) state_d = vaw_pkg::ST_IDLE;
      end
      default: state_d = vaw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      vaw_pkg::ST_SWEEP:  cmd_o.sweep = 1'b1;
      vaw_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      vaw_pkg::ST_EXEC:   cmd_o.exec   = 1'b1;
      vaw_pkg::ST_CHECK:  ;
      vaw_pkg::ST_COMMIT: cmd_o.commit = 1'b1;
      vaw_pkg::ST_DRAIN:  cmd_o.drain  = 1'b1;
      vaw_pkg::ST_REPORT: cmd_o.report = 1'b1;
      vaw_pkg::ST_RESP:   cmd_o.emit   = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vaw_pkg::ST_SWEEP;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  a_commit_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> cmd_o.drain)
    else $error("commit not followed by drain");

  a_pend_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == vaw_pkg::ST_IDLE) |-> !pend_q)
    else $error("clear result lost");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == vaw_pkg::ST_EXEC))
    else $error("accepted item not executed");

endmodule

>>> hw/rtl/vibration_activity_window_core.sv
// Top level of the vibration activity window core: stream ports and config port.
// Depends on vaw_pkg, vaw_ctrl, vaw_dp (which holds vaw_ram).
//
// Channel  Direction  Handshake                  Payload
// s_axis   in         s_axis_tvalid/tready       tdata: magnitude, tick_ms; tuser: command
// m_axis   out        m_axis_tvalid/tready       tdata: mode, active_buckets, running,
//                                                       should_sleep, report_ready
// cfg      in         cfg_we_i (no wait)         cfg_addr_i, cfg_wdata_i
//
// One item at a time. Sample, wake, take report and unused codes go from accept to
// result through execute and response; a tick also commits N seconds (N up to 66), by
// the read-then-clear of one ring RAM slot per second, and then checks the report
// interval; a clear sweeps the ring before its result.
// After reset and on clear the ring RAM is swept, one slot per cycle, with
// s_axis_tready low. The result register lets the next item enter while a result
// waits; a stalled result holds the controller before it writes the next one.
module vibration_activity_window_core #(
  parameter int unsigned WINDOW_SECONDS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] magnitude, [31:16] tick_ms
  input  logic [2:0]  s_axis_tuser,   // [2:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [0] mode, [7:1] active_buckets, [8] running,
                                      // [9] should_sleep, [10] report_ready, [15:11] zero
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i
);

  vaw_pkg::dp_cmd_t dp_cmd;
  vaw_pkg::dp_sts_t dp_sts;

  vaw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  vaw_dp #(
    .WINDOW_SECONDS (WINDOW_SECONDS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .sts_o        (dp_sts),
    .command_i    (s_axis_tuser),
    .magnitude_i  (s_axis_tdata[15:0]),
    .tick_ms_i    (s_axis_tdata[31:16]),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_data_o   (m_axis_tdata)
  );

endmodule

>>> dv/vaw_checker.sv
`timescale 1ns / 100ps
// Status checker for vibration_activity_window_core: watches the command, status and
// config ports, predicts each status item and compares it. Depends on vaw_pkg.
module vaw_checker #(
  parameter int unsigned WINDOW_SECONDS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  logic        cmd_ready_i,
  input  logic [31:0] cmd_data_i,
  input  logic [2:0]  cmd_user_i,
  input  logic        sts_valid_i,
  input  logic        sts_ready_i,
  input  logic [15:0] sts_data_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  // same bit layout as m_axis_tdata
  typedef struct packed {
    logic [4:0] pad;
    logic       report;
    logic       sleep;
    logic       running;
    logic [6:0] buckets;
    logic       mode;
  } status_t;

  logic [15:0]               vib_thr;
  logic [6:0]                run_thr;
  logic [31:0]               report_ivl;
  logic [31:0]               quiet_tmo;

  logic                      active_mode;
  logic [WINDOW_SECONDS-1:0] ring;
  int unsigned               ring_pos;
  logic                      second_hit;
  int unsigned               ms_acc;
  logic [31:0]               quiet_ms;
  logic [31:0]               report_ms;
  logic                      report_flag;

  status_t                   status_q[$];

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [15:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + b;
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  function automatic void clear_monitor();
    active_mode = 1'b0;
    ring        = '0;
    ring_pos    = 0;
    second_hit  = 1'b0;
    ms_acc      = 0;
    quiet_ms    = '0;
    report_ms   = '0;
    report_flag = 1'b0;
  endfunction

  function automatic status_t predict_status(logic [2:0] cmd, logic [15:0] mag,
                                             logic [15:0] ms);
    status_t     st;
    int unsigned nset;
    logic        flag_seen;
    case (cmd)
      vaw_pkg::CMD_SAMPLE: begin
        if (mag >= vib_thr) begin
          second_hit = 1'b1;
          quiet_ms   = '0;
        end
      end
      vaw_pkg::CMD_TICK: begin
        ms_acc    += ms;
        quiet_ms  = sat_add(quiet_ms, ms);
        report_ms = sat_add(report_ms, ms);
        while (ms_acc >= vaw_pkg::MS_PER_BUCKET) begin
          ms_acc         -= vaw_pkg::MS_PER_BUCKET;
          ring[ring_pos] = second_hit;
          ring_pos       = (ring_pos + 1) % WINDOW_SECONDS;
          ring[ring_pos] = 1'b0;
          second_hit     = 1'b0;
        end
        if (active_mode && report_ms >= report_ivl) begin
          report_ms   = '0;
          report_flag = 1'b1;
        end
      end
      vaw_pkg::CMD_WAKE: begin
        active_mode = 1'b1;
        quiet_ms    = '0;
      end
      vaw_pkg::CMD_CLEAR: clear_monitor();
      default: ;
    endcase
    flag_seen = report_flag;
    if (cmd == vaw_pkg::CMD_TAKE) report_flag = 1'b0;
    nset       = $countones(ring);
    st.pad     = '0;
    st.report  = flag_seen;
    st.sleep   = active_mode && (quiet_ms > quiet_tmo);
    st.running = nset >= run_thr;
    st.buckets = nset[6:0];
    st.mode    = active_mode;
    return st;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    status_t got;
    status_t want;
    if (!rst_ni) begin
      vib_thr      = 16'd100;
      run_thr      = 7'd10;
      report_ivl   = 32'd60000;
      quiet_tmo    = 32'd300000;
      clear_monitor();
      status_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (sts_valid_i && sts_ready_i) begin
        got = status_t'(sts_data_i);
        if (status_q.size() == 0) begin
          if (fail_count_o < 10) $display("%0t: status item with none expected: %h",
                                          $realtime, sts_data_i);
          fail_count_o++;
        end else begin
          want = status_q.pop_front();
          if (got !== want) begin
            if (fail_count_o < 10) begin
              $display("%0t: status mismatch", $realtime);
              $display("  expected mode=%0d buckets=%0d running=%0d sleep=%0d report=%0d pad=%h",
                       want.mode, want.buckets, want.running, want.sleep, want.report,
                       want.pad);
              $display("  actual   mode=%0d buckets=%0d running=%0d sleep=%0d report=%0d pad=%h",
                       got.mode, got.buckets, got.running, got.sleep, got.report, got.pad);
            end
            fail_count_o++;
          end
        end
      end
      if (cmd_valid_i && cmd_ready_i)
        status_q.push_back(predict_status(cmd_user_i, cmd_data_i[15:0], cmd_data_i[31:16]));
      if (cfg_we_i) begin
        case (cfg_addr_i)
          vaw_pkg::REG_VIB_THR:    vib_thr    = cfg_wdata_i[15:0];
          vaw_pkg::REG_RUN_THR:    run_thr    = cfg_wdata_i[6:0];
          vaw_pkg::REG_REPORT_IVL: report_ivl = cfg_wdata_i;
          vaw_pkg::REG_QUIET_TMO:  quiet_tmo  = cfg_wdata_i;
          default: ;
        endcase
      end
      pending_o = status_q.size();
    end
  end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// Testbench top for vibration_activity_window_core: clock, reset, command stimulus,
// status back-pressure, idle watchdog and verdict. Depends on vaw_pkg, the core and vaw_checker.
module testbench;

  localparam int unsigned WINDOW        = 64;
  localparam int unsigned IDLE_LIMIT    = 3000;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned HOLD_CYCLES   = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        cfg_we_i;
  logic [1:0]  cfg_addr_i;
  logic [31:0] cfg_wdata_i;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_cycles = 0;
  logic        rx_hold_req = 1'b0;
  logic        tx_bursty   = 1'b0;
  logic [15:0] vib_now     = 16'd100;

  vibration_activity_window_core #(
    .WINDOW_SECONDS(WINDOW)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  vaw_checker #(
    .WINDOW_SECONDS(WINDOW)
  ) status_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid),
    .cmd_ready_i (s_axis_tready),
    .cmd_data_i  (s_axis_tdata),
    .cmd_user_i  (s_axis_tuser),
    .sts_valid_i (m_axis_tvalid),
    .sts_ready_i (m_axis_tready),
    .sts_data_i  (m_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #10 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 80);
    return $urandom_range(1, 3);
  endfunction

  function automatic int unsigned next_gap();
    if (!tx_bursty || $urandom_range(0, 1) == 0) return 0;
    return pick_gap();
  endfunction

  function automatic logic [15:0] hot_mag();
    return vib_now + 16'($urandom_range(0, 16'hFFFF - vib_now));
  endfunction

  task automatic send_item(input logic [2:0] cmd, input logic [15:0] mag,
                           input logic [15:0] ms, input int unsigned gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {ms, mag};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_regs(input logic [15:0] vib, input logic [6:0] run,
                            input logic [31:0] ivl, input logic [31:0] tmo);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= vaw_pkg::REG_VIB_THR;
    cfg_wdata_i <= {16'd0, vib};
    @(negedge clk_i);
    cfg_addr_i  <= vaw_pkg::REG_RUN_THR;
    cfg_wdata_i <= {25'd0, run};
    @(negedge clk_i);
    cfg_addr_i  <= vaw_pkg::REG_REPORT_IVL;
    cfg_wdata_i <= ivl;
    @(negedge clk_i);
    cfg_addr_i  <= vaw_pkg::REG_QUIET_TMO;
    cfg_wdata_i <= tmo;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    vib_now     = vib;
  endtask

  task automatic send_random();
    int unsigned pick;
    logic [2:0]  cmd;
    logic [15:0] mag;
    logic [15:0] ms;
    pick = $urandom_range(0, 99);
    if (pick < 40)      cmd = vaw_pkg::CMD_SAMPLE;
    else if (pick < 78) cmd = vaw_pkg::CMD_TICK;
    else if (pick < 86) cmd = vaw_pkg::CMD_WAKE;
    else if (pick < 87) cmd = vaw_pkg::CMD_CLEAR;
    else if (pick < 95) cmd = vaw_pkg::CMD_TAKE;
    else                cmd = 3'($urandom_range(5, 7));
    case ($urandom_range(0, 5))
      0:       mag = 16'($urandom);
      1:       mag = vib_now;
      2:       mag = vib_now - 16'd1;
      3:       mag = 16'($urandom_range(0, vib_now));
      default: mag = hot_mag();
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 2)       ms = 16'($urandom);
    else if (pick < 10) ms = vaw_pkg::MS_PER_BUCKET[15:0];
    else if (pick < 15) ms = 16'd0;
    else                ms = 16'($urandom_range(1, 1500));
    send_item(cmd, mag, ms, next_gap());
  endtask

  // activity bursts: hot sample then about one second of ticks
  task automatic send_bursts(input int unsigned pairs);
    for (int unsigned k = 0; k < pairs; k++) begin
      send_item(vaw_pkg::CMD_SAMPLE, hot_mag(), 16'($urandom), next_gap());
      send_item(vaw_pkg::CMD_TICK, 16'($urandom), 16'($urandom_range(950, 1050)),
                next_gap());
    end
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned done_items;
    int unsigned tx_span;
    int unsigned pairs;
    done_items = 0;
    tx_span    = 0;
    while (done_items < count) begin
      if (tx_span == 0) begin
        tx_bursty = $urandom_range(0, 1);
        tx_span   = $urandom_range(20, 60);
      end
      if ($urandom_range(0, 19) == 0) begin
        pairs = $urandom_range(3, 15);
        send_bursts(pairs);
        done_items += 2 * pairs;
        tx_span = (tx_span > 2 * pairs) ? tx_span - 2 * pairs : 0;
      end else begin
        send_random();
        done_items++;
        tx_span--;
      end
    end
  endtask

  initial begin : receiver
    int unsigned span;
    int unsigned rx_gap;
    logic        rx_bursty;
    span          = 0;
    rx_gap        = 0;
    rx_bursty     = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (span == 0) begin
        rx_bursty = $urandom_range(0, 1);
        span      = $urandom_range(50, 300);
      end
      span--;
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_gap      = HOLD_CYCLES;
      end
      if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else if (rx_bursty && $urandom_range(0, 2) == 0) begin
        rx_gap        = pick_gap() - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = vaw_pkg::CMD_SAMPLE;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = vaw_pkg::REG_VIB_THR;
    cfg_wdata_i   = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed, reset register values
    send_item(vaw_pkg::CMD_TAKE,   16'd0,     16'd0,     0);
    send_item(vaw_pkg::CMD_SAMPLE, 16'd99,    16'd0,     0);
    send_item(vaw_pkg::CMD_SAMPLE, 16'd100,   16'd0,     0);
    send_item(vaw_pkg::CMD_SAMPLE, 16'hFFFF,  16'd0,     0);
    send_item(vaw_pkg::CMD_SAMPLE, 16'd0,     16'd0,     0);
    send_item(vaw_pkg::CMD_TICK,   16'd0,     16'd999,   0);
    send_item(vaw_pkg::CMD_TICK,   16'd0,     16'd1,     0);
    send_item(vaw_pkg::CMD_TICK,   16'd0,     16'd0,     0);
    send_item(vaw_pkg::CMD_TICK,   16'd0,     16'd1000,  0);
    send_item(3'd5,                16'hFFFF,  16'hFFFF,  0);
    send_item(3'd6,                16'hFFFF,  16'hFFFF,  0);
    send_item(3'd7,                16'hFFFF,  16'hFFFF,  0);
    send_item(vaw_pkg::CMD_WAKE,   16'd0,     16'd0,     0);
    send_item(vaw_pkg::CMD_SAMPLE, 16'd500,   16'd0,     0);
    send_item(vaw_pkg::CMD_TICK,   16'd0,     16'hFFFF,  0);
    send_item(vaw_pkg::CMD_TAKE,   16'd0,     16'd0,     0);
    send_item(vaw_pkg::CMD_TAKE,   16'd0,     16'd0,     0);
    send_item(vaw_pkg::CMD_TICK,   16'd0,     16'hFFFF,  0);
    send_item(vaw_pkg::CMD_CLEAR,  16'd0,     16'd0,     0);
    send_item(vaw_pkg::CMD_SAMPLE, 16'hFFFF,  16'd0,     0);
    send_item(vaw_pkg::CMD_TICK,   16'd0,     16'd1000,  0);
    send_item(vaw_pkg::CMD_WAKE,   16'd0,     16'd0,     0);
    send_item(vaw_pkg::CMD_TICK,   16'd0,     16'd1,     0);
    send_item(vaw_pkg::CMD_TAKE,   16'd0,     16'd0,     0);

    // low extremes: zero interval reports on every active tick
    write_regs(16'd0, 7'd0, 32'd0, 32'd0);
    send_item(vaw_pkg::CMD_WAKE, 16'd0, 16'd0, 0);
    run_random(330);

    // high extremes: fill the whole window with activity
    write_regs(16'hFFFF, 7'd64, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(vaw_pkg::CMD_CLEAR, 16'd0, 16'd0, 0);
    send_item(vaw_pkg::CMD_WAKE, 16'd0, 16'd0, 0);
    send_bursts(70);
    run_random(200);

    // mid settings with back-pressure and a full pause
    write_regs(16'($urandom_range(0, 2000)), 7'($urandom_range(1, 16)),
               $urandom_range(500, 20000), $urandom_range(0, 3000));
    rx_hold_req = 1'b1;
    tx_bursty   = 1'b0;
    for (int unsigned k = 0; k < 12; k++) send_random();
    run_random(150);
    wait_drained();
    run_random(150);

    write_regs(16'($urandom), 7'($urandom_range(0, 64)),
               $urandom_range(1, 200000), $urandom_range(0, 100000));
    run_random(350);

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> vibration_activity_window_core.f
hw/rtl/vaw_pkg.sv
hw/rtl/vaw_ram.sv
hw/rtl/vaw_dp.sv
hw/rtl/vaw_ctrl.sv
hw/rtl/vibration_activity_window_core.sv
dv/vaw_checker.sv
dv/testbench.sv
